[sv/qams_pkg.sv]
// ----------------------------------------------------------------------------
// Queue-aware multipath selector package
// Shared widths, register indexes, record types and small helper functions.
// ----------------------------------------------------------------------------
package qams_pkg;

  localparam int FLOWS      = 128;
  localparam int FLOW_W     = $clog2(FLOWS);
  localparam int MAX_PATHS  = 4;
  localparam int PATH_W     = 2;
  localparam int SLOTS      = 8;
  localparam int SLOT_W     = 3;
  localparam int RR_TRIES   = SLOTS + 1;
  localparam int TRY_W      = 4;
  localparam int QLEN_W     = 10;
  localparam int EST_W      = QLEN_W + 1;
  localparam int TIME_W     = 48;
  localparam int DRAIN_W    = 20;
  localparam int BYTES_W    = 16;
  localparam int PC_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_NS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOT    = 3'd5;

  // Register reset values.
  localparam logic [PC_W-1:0]    RST_PATH_COUNT = 3'd4;
  localparam logic [BYTES_W-1:0] RST_FULL_SIZE  = 16'd1500;
  localparam logic [DRAIN_W-1:0] RST_DRAIN_NS   = 20'd12000;
  localparam logic [QLEN_W-1:0]  RST_QUEUE_THR  = 10'd41;
  localparam logic [SLOTS-1:0]   RST_SLOT_MASK  = 8'd15;
  localparam logic [SLOT_W-1:0]  RST_MAX_SLOT   = 3'd3;

  typedef logic [QLEN_W-1:0] qlen_t;
  typedef qlen_t [MAX_PATHS-1:0] qlen_vec_t;
  typedef logic [PATH_W-1:0] path_t;

  typedef struct packed {
    logic [TIME_W-1:0] last_time;
    qlen_t             last_queue;
    path_t             last_path;
  } flow_rec_t;

  // Path count clamped into 1..MAX_PATHS.
  function automatic logic [PC_W-1:0] eff_paths(input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] c;
    c = pc;
    if (c == '0) c = PC_W'(1);
    if (c > PC_W'(MAX_PATHS)) c = PC_W'(MAX_PATHS);
    return c;
  endfunction

  // Lowest-numbered path among the considered ones with the shortest queue.
  function automatic path_t first_shortest(input qlen_vec_t q, input logic [PC_W-1:0] c);
    path_t best;
    best = '0;
    for (int i = 1; i < MAX_PATHS; i++) begin
      if (i < int'(c) && q[i] < q[best]) best = path_t'(i);
    end
    return best;
  endfunction

  // Round-robin wrap: x modulo m for x up to SLOTS and m in 1..SLOTS.
  function automatic logic [SLOT_W-1:0] rr_wrap(input logic [SLOT_W:0] x,
                                                 input logic [SLOT_W:0] m);
    logic [SLOT_W:0] r;
    r = x;
    for (int i = 0; i < SLOTS; i++) begin
      if (r >= m) r = r - m;
    end
    return r[SLOT_W-1:0];
  endfunction

endpackage

[sv/qams_divider.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of the elapsed time by the drain time, one quotient bit
// per clock cycle.
// ----------------------------------------------------------------------------
module qams_divider
  import qams_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TIME_W-1:0]  dividend,
  input  logic [DRAIN_W-1:0] divisor,
  output logic               done,
  output logic [TIME_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(TIME_W);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TIME_W-1:0]  dvd_r, dvd_nxt;
  logic [DRAIN_W-1:0] rem_r, rem_nxt;
  logic [DRAIN_W-1:0] div_r, div_nxt;
  logic [DRAIN_W:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem_r, dvd_r[TIME_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (run_r) begin
      // The partial remainder always stays below the divisor, so it fits.
      rem_nxt = ge ? DRAIN_W'(rem_sh - {1'b0, div_r}) : rem_sh[DRAIN_W-1:0];
      dvd_nxt = {dvd_r[TIME_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(TIME_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

[sv/queue_aware_multipath_selector_unit.sv]
// ----------------------------------------------------------------------------
// Queue-aware multipath selector
// Result path: a flow's first packet is answered straight from the lookup state,
// round robin tries one slot per cycle until it stops, and a full-size packet
// waits in the divide state for the serial divide of the elapsed time, then picks.
// One transaction at a time: busy stays high until the result strobe, so the
// next transaction can be accepted in the same cycle as the previous result.
// Synchronous reset loads the register defaults and clears the flow-seen bits
// and the round-robin pointer.
// ----------------------------------------------------------------------------
module queue_aware_multipath_selector_unit
  import qams_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FLOW_W-1:0]     in_flow_id,
  input  logic [BYTES_W-1:0]    in_packet_bytes,
  input  logic [TIME_W-1:0]     in_arrival_ns,
  input  logic [QLEN_W-1:0]     in_queue_len_1,
  input  logic [QLEN_W-1:0]     in_queue_len_2,
  input  logic [QLEN_W-1:0]     in_queue_len_3,
  input  logic [QLEN_W-1:0]     in_queue_len_4,
  output logic                  out_valid,
  output logic [SLOT_W-1:0]     out_port,
  output logic                  out_chose_by_queue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_RR     = 3'd4;

  // Configuration registers.
  logic [PC_W-1:0]    path_count_r;
  logic [BYTES_W-1:0] full_size_r;
  logic [DRAIN_W-1:0] drain_r;
  logic [QLEN_W-1:0]  thr_r;
  logic [SLOTS-1:0]   slot_mask_r;
  logic [SLOT_W-1:0]  max_slot_r;

  // Sequencer and transaction state.
  logic [2:0]         state_r, state_nxt;
  logic [FLOW_W-1:0]  flow_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [TIME_W-1:0]  now_r;
  qlen_vec_t          q_r;
  flow_rec_t          rec_r;
  logic [FLOWS-1:0]   seen_r;
  logic [EST_W-1:0]   est_r, est_nxt;
  logic [SLOT_W-1:0]  rr_next_r, rr_next_nxt;
  logic [SLOT_W-1:0]  rr_start_r, rr_start_nxt;
  logic [TRY_W-1:0]   tries_r, tries_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_port_r, out_port_nxt;
  logic               out_byq_r, out_byq_nxt;

  flow_rec_t          flow_mem [FLOWS];
  flow_rec_t          wr_rec;
  logic               mem_we;
  logic               seen_set;

  logic               accept;
  logic [PC_W-1:0]    pc_eff;
  path_t              fs;
  logic               seen_hit;
  logic               full_hit;
  logic [TIME_W-1:0]  elapsed;
  logic [DRAIN_W-1:0] drain_eff;
  logic               div_start;
  logic               div_done;
  logic [TIME_W-1:0]  div_quo;
  logic [EST_W-1:0]   base;
  logic [EST_W-1:0]   est_c;
  qlen_t              pick_m;
  path_t              pick_p;
  logic [SLOT_W-1:0]  rr_cl;
  logic [SLOT_W-1:0]  rr_nx;
  logic [TRY_W-1:0]   tries_inc;
  logic               rr_stop;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;

  assign pc_eff   = eff_paths(path_count_r);
  assign fs       = first_shortest(q_r, pc_eff);
  assign seen_hit = seen_r[flow_r];
  assign full_hit = bytes_r == full_size_r;

  // Time running backwards counts as no time gone by.
  assign elapsed   = (now_r >= rec_r.last_time) ? now_r - rec_r.last_time : '0;
  assign drain_eff = (drain_r == '0) ? DRAIN_W'(1) : drain_r;
  assign div_start = (state_r == ST_LOOKUP) && seen_hit && full_hit;

  qams_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (drain_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Estimated remaining length: recorded length plus one minus drained count.
  assign base  = {1'b0, rec_r.last_queue} + EST_W'(1);
  assign est_c = (div_quo <= TIME_W'(base)) ? base - div_quo[EST_W-1:0] : '0;

  always_comb begin
    pick_m = q_r[rec_r.last_path];
    pick_p = rec_r.last_path;
    for (int i = 0; i < MAX_PATHS; i++) begin
      if (i < int'(pc_eff) && {1'b0, q_r[i]} >= est_r && q_r[i] < pick_m) pick_m = q_r[i];
    end
    // On a tie the last matching path wins.
    for (int i = 0; i < MAX_PATHS; i++) begin
      if (i < int'(pc_eff) && q_r[i] == pick_m) pick_p = path_t'(i);
    end
    if (pick_m > thr_r) begin
      pick_p = fs;
      pick_m = q_r[fs];
    end
  end

  assign rr_cl     = rr_next_r;
  assign rr_nx     = rr_wrap({1'b0, rr_cl} + (SLOT_W+1)'(1),
                             {1'b0, max_slot_r} + (SLOT_W+1)'(1));
  assign tries_inc = tries_r + TRY_W'(1);
  assign rr_stop   = slot_mask_r[rr_cl] || (rr_nx == rr_start_r) ||
                     (tries_inc >= TRY_W'(RR_TRIES));

  always_comb begin
    state_nxt     = state_r;
    est_nxt       = est_r;
    rr_next_nxt   = rr_next_r;
    rr_start_nxt  = rr_start_r;
    tries_nxt     = tries_r;
    out_valid_nxt = 1'b0;
    out_port_nxt  = out_port_r;
    out_byq_nxt   = out_byq_r;
    mem_we        = 1'b0;
    seen_set      = 1'b0;
    wr_rec        = '{last_time: now_r, last_queue: pick_m, last_path: pick_p};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!seen_hit) begin
          mem_we        = 1'b1;
          seen_set      = 1'b1;
          wr_rec        = '{last_time: now_r, last_queue: q_r[fs], last_path: fs};
          out_valid_nxt = 1'b1;
          out_port_nxt  = SLOT_W'(fs);
          out_byq_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (full_hit) begin
          state_nxt = ST_DIV;
        end else begin
          rr_start_nxt = rr_next_r;
          tries_nxt    = '0;
          state_nxt    = ST_RR;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          est_nxt   = est_c;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        mem_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_port_nxt  = SLOT_W'(pick_p);
        out_byq_nxt   = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RR: begin
        rr_next_nxt = rr_nx;
        tries_nxt   = tries_inc;
        if (rr_stop) begin
          out_valid_nxt = 1'b1;
          out_port_nxt  = rr_cl;
          out_byq_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      rr_next_r   <= '0;
      rr_start_r  <= '0;
      tries_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rr_next_r   <= rr_next_nxt;
      rr_start_r  <= rr_start_nxt;
      tries_r     <= tries_nxt;
      out_valid_r <= out_valid_nxt;
      if (seen_set) seen_r[flow_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_count_r <= RST_PATH_COUNT;
      full_size_r  <= RST_FULL_SIZE;
      drain_r      <= RST_DRAIN_NS;
      thr_r        <= RST_QUEUE_THR;
      slot_mask_r  <= RST_SLOT_MASK;
      max_slot_r   <= RST_MAX_SLOT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATH_COUNT: path_count_r <= cfg_data[PC_W-1:0];
        CFG_FULL_SIZE:  full_size_r  <= cfg_data[BYTES_W-1:0];
        CFG_DRAIN_NS:   drain_r      <= cfg_data[DRAIN_W-1:0];
        CFG_QUEUE_THR:  thr_r        <= cfg_data[QLEN_W-1:0];
        CFG_SLOT_MASK:  slot_mask_r  <= cfg_data[SLOTS-1:0];
        CFG_MAX_SLOT:   max_slot_r   <= cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    est_r      <= est_nxt;
    out_port_r <= out_port_nxt;
    out_byq_r  <= out_byq_nxt;
    if (accept) begin
      flow_r  <= in_flow_id;
      bytes_r <= in_packet_bytes;
      now_r   <= in_arrival_ns;
      q_r     <= {in_queue_len_4, in_queue_len_3, in_queue_len_2, in_queue_len_1};
    end
  end

  // Per-flow record memory: read on the accepting edge, written on a queue-aware result.
  always_ff @(posedge clk) begin
    if (accept) rec_r <= flow_mem[in_flow_id];
  end

  always_ff @(posedge clk) begin
    if (mem_we) flow_mem[flow_r] <= wr_rec;
  end

  assign out_valid          = out_valid_r;
  assign out_port           = out_port_r;
  assign out_chose_by_queue = out_byq_r;

endmodule

[sv/qams_checker.sv]
// ----------------------------------------------------------------------------
// Queue-aware multipath selector checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module qams_checker
  import qams_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [SLOT_W-1:0] out_port,
  input logic              out_chose_by_queue
);

  // An accepted transaction makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  // Each result closes a transaction that was in progress.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // Finishing a transaction shows its result in the same cycle.
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // One result per transaction: strobes never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Queue-aware choices always name one of the paths.
  a_queue_port: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_chose_by_queue) |-> (out_port < SLOT_W'(MAX_PATHS)))
    else $error("queue-aware choice outside the path range");

endmodule

bind queue_aware_multipath_selector_unit qams_checker u_qams_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_port           (out_port),
  .out_chose_by_queue (out_chose_by_queue)
);
